// ===== hw/rtl/mcc_pkg.sv =====
// Shared types, constants and helpers for the Mahalanobis color classifier.
// No dependencies; every other RTL file imports this package.
package mcc_pkg;

  localparam int COEF_WIDTH_DEF = 20;
  localparam int COEF_FRAC      = 18;
  localparam int MEAN_FRAC      = 4;
  localparam int PROD_FRAC      = COEF_FRAC + 2 * MEAN_FRAC;

  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 12;
  localparam int DIFF_W     = 13;
  localparam int MM_W       = 2 * DIFF_W;
  localparam int NUM_CH     = 3;
  localparam int NUM_PAIRS  = 6;
  localparam int NUM_PARTS  = 3;

  localparam int ROW_W      = 60;
  localparam int ROW_EXT_W  = 64;
  localparam int MEAN_REG_W = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  localparam int MASK_W = 8;
  localparam int DIST_W = 22;

  localparam logic [MASK_W-1:0] MASK_ON     = 8'd255;
  localparam logic [MASK_W-1:0] MASK_OFF    = 8'd0;
  localparam logic [DIST_W-1:0] DIST_MAX    = 22'h3FFFFF;
  localparam logic [DIST_W-1:0] LIMIT_RESET = 22'd750;

  // Pair order: 00, 11, 22, 01, 02, 12
  localparam int PAIR_A [NUM_PAIRS] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_ZERO = 3'd0,
    CFG_ROW_ONE  = 3'd1,
    CFG_ROW_TWO  = 3'd2,
    CFG_MEAN     = 3'd3,
    CFG_LIMIT    = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [MASK_W-1:0] mask;
  } result_t;

  function automatic logic signed [MM_W-1:0] mul_diff(logic signed [DIFF_W-1:0] a,
                                                       logic signed [DIFF_W-1:0] b);
    logic signed [MM_W-1:0] ae;
    logic signed [MM_W-1:0] be;
    ae = MM_W'(a);
    be = MM_W'(b);
    return ae * be;
  endfunction

endpackage

// ===== hw/rtl/mcc_diff_square.sv =====
// Stages one and two: mean subtraction per channel, then the six pairwise
// products of the difference vector. Depends on mcc_pkg.
module mcc_diff_square import mcc_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pixel_t                           pix_i,
  input  logic [MEAN_REG_W-1:0]            mean_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [NUM_PAIRS-1:0][MM_W-1:0] mm_o
);

  logic                      s1_v_q, s2_v_q;
  logic                      rdy1, rdy2;
  logic [NUM_CH*PIX_W-1:0]   pix_flat;
  logic signed [DIFF_W-1:0]  diff_d [NUM_CH];
  logic signed [DIFF_W-1:0]  diff_q [NUM_CH];
  logic signed [NUM_PAIRS-1:0][MM_W-1:0] mm_d, mm_q;

  assign rdy2       = !s2_v_q || out_ready_i;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;
  assign pix_flat   = pix_i;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      diff_d[c] = $signed({1'b0, pix_flat[c*PIX_W +: PIX_W], 4'b0000})
                - $signed({1'b0, mean_i[c*MEAN_W +: MEAN_W]});
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      mm_d[p] = mul_diff(diff_q[PAIR_A[p]], diff_q[PAIR_B[p]]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      for (int c = 0; c < NUM_CH; c++) diff_q[c] <= diff_d[c];
    end
    if (rdy2 && s1_v_q) mm_q <= mm_d;
  end

  assign out_valid_o = s2_v_q;
  assign mm_o        = mm_q;

endmodule

// ===== hw/rtl/mcc_coef_mult.sv =====
// Stage three: each pairwise product times its combined coefficient.
// Depends on mcc_pkg.
module mcc_coef_mult import mcc_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int CC_W      = COEF_WIDTH + 1,
  localparam int TERM_W    = MM_W + CC_W
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [NUM_PAIRS-1:0][MM_W-1:0] mm_i,
  input  logic signed [NUM_PAIRS-1:0][CC_W-1:0] coef_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [NUM_PAIRS-1:0][TERM_W-1:0] term_o
);

  logic s3_v_q;
  logic rdy3;
  logic signed [NUM_PAIRS-1:0][TERM_W-1:0] term_d, term_q;
  logic signed [TERM_W-1:0] mm_ext [NUM_PAIRS];
  logic signed [TERM_W-1:0] cc_ext [NUM_PAIRS];

  assign rdy3       = !s3_v_q || out_ready_i;
  assign in_ready_o = rdy3;

  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      mm_ext[p] = TERM_W'($signed(mm_i[p]));
      cc_ext[p] = TERM_W'($signed(coef_i[p]));
      term_d[p] = mm_ext[p] * cc_ext[p];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (rdy3) begin
      s3_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) term_q <= term_d;
  end

  assign out_valid_o = s3_v_q;
  assign term_o      = term_q;

endmodule

// ===== hw/rtl/mcc_reduce.sv =====
// Stages four to six: adder tree over the six terms, then threshold test
// and saturation into the output register. Depends on mcc_pkg.
module mcc_reduce import mcc_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int TERM_W    = MM_W + COEF_WIDTH + 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [NUM_PAIRS-1:0][TERM_W-1:0] term_i,
  input  logic [DIST_W-1:0]                       limit_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output result_t                                 result_o
);

  localparam int PART_W  = TERM_W + 1;
  localparam int SUM_W   = TERM_W + 3;
  localparam int WHOLE_W = SUM_W - PROD_FRAC;
  localparam int CMP_W   = (WHOLE_W > DIST_W) ? WHOLE_W : DIST_W;

  logic s4_v_q, s5_v_q, out_v_q;
  logic rdy4, rdy5, rdy6;
  logic signed [PART_W-1:0] part_d [NUM_PARTS];
  logic signed [PART_W-1:0] part_q [NUM_PARTS];
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [PART_W-1:0] term_a, term_b;
  logic signed [SUM_W-1:0]  p0, p1, p2;
  logic                     neg;
  logic                     frac_nz;
  logic [CMP_W-1:0]         whole_ext, limit_ext;
  logic [MASK_W-1:0]        mask_d, mask_q;
  logic [DIST_W-1:0]        dist_d, dist_q;

  assign rdy6       = !out_v_q || out_ready_i;
  assign rdy5       = !s5_v_q || rdy6;
  assign rdy4       = !s4_v_q || rdy5;
  assign in_ready_o = rdy4;

  always_comb begin
    for (int j = 0; j < NUM_PARTS; j++) begin
      term_a    = PART_W'($signed(term_i[2*j]));
      term_b    = PART_W'($signed(term_i[2*j+1]));
      part_d[j] = term_a + term_b;
    end
  end

  always_comb begin
    p0    = SUM_W'(part_q[0]);
    p1    = SUM_W'(part_q[1]);
    p2    = SUM_W'(part_q[2]);
    sum_d = p0 + p1 + p2;
  end

  always_comb begin
    neg       = sum_q[SUM_W-1];
    frac_nz   = |sum_q[PROD_FRAC-1:0];
    whole_ext = CMP_W'(sum_q[SUM_W-1:PROD_FRAC]);
    limit_ext = CMP_W'(limit_i);
    if (neg || (whole_ext < limit_ext) || ((whole_ext == limit_ext) && !frac_nz)) begin
      mask_d = MASK_ON;
    end else begin
      mask_d = MASK_OFF;
    end
    if (neg) begin
      dist_d = '0;
    end else if (whole_ext > CMP_W'(DIST_MAX)) begin
      dist_d = DIST_MAX;
    end else begin
      dist_d = whole_ext[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy4) s4_v_q  <= in_valid_i;
      if (rdy5) s5_v_q  <= s4_v_q;
      if (rdy6) out_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_valid_i) begin
      for (int j = 0; j < NUM_PARTS; j++) part_q[j] <= part_d[j];
    end
    if (rdy5 && s4_v_q) sum_q <= sum_d;
    if (rdy6 && s5_v_q) begin
      mask_q <= mask_d;
      dist_q <= dist_d;
    end
  end

  assign out_valid_o       = out_v_q;
  assign result_o.mask     = mask_q;
  assign result_o.distance = dist_q;

  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_v_q && !rdy6) |=> (s5_v_q && $stable(sum_q)))
    else $error("sum stage lost its item under stall");

  a_neg_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_v_q && rdy6 && sum_q[SUM_W-1]) |=> (out_v_q && mask_q == MASK_ON && dist_q == '0))
    else $error("negative distance gave wrong result");

  a_far_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (dist_q > limit_i)) |-> (mask_q == MASK_OFF))
    else $error("distance above limit but mask set");

endmodule

// ===== hw/rtl/mahalanobis_color_classifier.sv =====
// Mahalanobis color classifier: configuration registers and a six-stage pipeline.
// Throughput one item per cycle while the output is not stalled by m_axis_tready_i.
// Stages: mean subtract, pair products, coefficient multiply, two adder levels, decide.
// Each stage holds its item when the next is full, so bubbles close under output stall.
// Reset clears all stage valid bits, zeroes coefficients and means, limit resets to 750.
// Depends on mcc_pkg, mcc_diff_square, mcc_coef_mult and mcc_reduce.
module mahalanobis_color_classifier import mcc_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [7:0] pixel_blue, [15:8] pixel_green, [23:16] pixel_red
  input  logic [23:0]           s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] mask_value, [29:8] distance_whole, [31:30] zero
  output logic [31:0]           m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CC_W   = COEF_WIDTH + 1;
  localparam int TERM_W = MM_W + CC_W;

  logic [ROW_W-1:0]      row_q [NUM_CH];
  logic [MEAN_REG_W-1:0] mean_q;
  logic [DIST_W-1:0]     limit_q;

  logic [ROW_EXT_W-1:0]           row_ext [NUM_CH];
  logic signed [COEF_WIDTH-1:0]   coef [NUM_CH][NUM_CH];
  logic signed [CC_W-1:0]         cc_a, cc_b;
  logic signed [NUM_PAIRS-1:0][CC_W-1:0] coef_comb;

  logic                                    ds_valid, ds_ready;
  logic signed [NUM_PAIRS-1:0][MM_W-1:0]   mm;
  logic                                    cm_valid, cm_ready;
  logic signed [NUM_PAIRS-1:0][TERM_W-1:0] term;
  result_t                                 result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_CH; r++) row_q[r] <= '0;
      mean_q  <= '0;
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ROW_ZERO: row_q[0] <= cfg_data_i[ROW_W-1:0];
        CFG_ROW_ONE:  row_q[1] <= cfg_data_i[ROW_W-1:0];
        CFG_ROW_TWO:  row_q[2] <= cfg_data_i[ROW_W-1:0];
        CFG_MEAN:     mean_q   <= cfg_data_i[MEAN_REG_W-1:0];
        CFG_LIMIT:    limit_q  <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Fold the off-diagonal pairs: m_i*m_k shares C[i][k] + C[k][i]
  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      row_ext[r] = ROW_EXT_W'(row_q[r]);
      for (int k = 0; k < NUM_CH; k++) begin
        coef[r][k] = $signed(row_ext[r][k*COEF_WIDTH +: COEF_WIDTH]);
      end
    end
    for (int p = 0; p < NUM_PAIRS; p++) begin
      cc_a = CC_W'(coef[PAIR_A[p]][PAIR_B[p]]);
      cc_b = CC_W'(coef[PAIR_B[p]][PAIR_A[p]]);
      if (PAIR_A[p] == PAIR_B[p]) begin
        coef_comb[p] = cc_a;
      end else begin
        coef_comb[p] = cc_a + cc_b;
      end
    end
  end

  mcc_diff_square u_diff_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .pix_i       (pixel_t'(s_axis_tdata_i)),
    .mean_i      (mean_q),
    .out_valid_o (ds_valid),
    .out_ready_i (ds_ready),
    .mm_o        (mm)
  );

  mcc_coef_mult #(.COEF_WIDTH(COEF_WIDTH)) u_coef_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ds_valid),
    .in_ready_o  (ds_ready),
    .mm_i        (mm),
    .coef_i      (coef_comb),
    .out_valid_o (cm_valid),
    .out_ready_i (cm_ready),
    .term_o      (term)
  );

  mcc_reduce #(.COEF_WIDTH(COEF_WIDTH)) u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cm_valid),
    .in_ready_o  (cm_ready),
    .term_i      (term),
    .limit_i     (limit_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tdata_o = {2'b00, result};

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while output side could drain");

endmodule
